// ===== hdl/aligned_stack_allocator_top_macros.svh =====
`ifndef ALIGNED_STACK_ALLOCATOR_TOP_MACROS_SVH
`define ALIGNED_STACK_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define ASA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ASA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/asa_pkg.sv =====
package asa_pkg;

  localparam int MAX_FRAMES        = 64;
  localparam int FRAME_IDX_W       = $clog2(MAX_FRAMES);
  localparam int COUNT_W           = $clog2(MAX_FRAMES + 1);
  localparam int HEADER_SIZE       = 16;
  localparam int HEADER_ALIGN_LOG2 = 3;
  localparam int ADDR_W            = 32;
  localparam int PAD_W             = 16;
  localparam int CFG_IDX_W         = 1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NO_SPACE = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_NOT_TOP  = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS = 1'b0,
    CFG_CAPACITY     = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_CALC = 1'b1
  } state_t;

  typedef struct packed {
    logic [31:0] frame_start;
    logic [31:0] payload;
  } frame_t;

  typedef struct packed {
    logic                   we;
    logic [FRAME_IDX_W-1:0] waddr;
    frame_t                 wdata;
    logic                   re;
    logic [FRAME_IDX_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [PAD_W-1:0] align_mask(input logic [3:0] lg);
    logic [PAD_W-1:0] m;
    m = (PAD_W'(1) << lg) - PAD_W'(1);
    if (lg < 4'(HEADER_ALIGN_LOG2)) begin
      m = (PAD_W'(1) << HEADER_ALIGN_LOG2) - PAD_W'(1);
    end
    return m;
  endfunction

endpackage

// ===== hdl/asa_if.sv =====
interface asa_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] size;
  logic [3:0]  align_log2;
  logic        check_top;
  logic [31:0] free_address;

  modport source (output valid, op, size, align_log2, check_top, free_address, input ready);
  modport sink (input valid, op, size, align_log2, check_top, free_address, output ready);
endinterface

interface asa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic [2:0]  status;

  modport source (output valid, address, status, input ready);
  modport sink (input valid, address, status, output ready);
endinterface

// ===== hdl/aligned_stack_allocator_top.sv =====
// Aligned stack allocator: last-in-first-out allocation over one buffer.
// Requests enter on in_if (valid/ready): op selects allocate or free; an
// allocate carries size and align_log2, a free may check free_address
// against the top payload when check_top is set.
// Results leave on out_if (valid/ready): payload address and status.
// Exactly one result per request.
// A result is registered in the update state (S_CALC) once the output register
// is free. No new request is taken until that update is done: the top frame
// entry is read from the frame memory through a register before the update.
// A new request is taken while the previous result still waits in the
// output register; if the receiver stalls, the next result holds in the
// update stage and no further request is taken until the output frees.
// cfg_we/cfg_index/cfg_data write base_address (0) and capacity (1); the user
// must write them only while the block is idle: the block does not enforce it.
// Reset (rst_n low, synchronous) empties the stack, clears the used count,
// sets base_address to 0 and capacity to 4096. The frame memory needs no
// clearing: only entries below the frame count are ever used.
module aligned_stack_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  asa_req_if.sink                       in_if,
  asa_rsp_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [asa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  logic [31:0]       base_address_r;
  logic [31:0]       capacity_r;
  asa_pkg::mem_req_t mem_req;
  asa_pkg::frame_t   mem_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r <= '0;
      capacity_r     <= 32'd4096;
    end else if (cfg_we) begin
      case (asa_pkg::cfg_idx_t'(cfg_index))
        asa_pkg::CFG_BASE_ADDRESS: base_address_r <= cfg_data;
        asa_pkg::CFG_CAPACITY:     capacity_r     <= cfg_data;
        default: begin
          base_address_r <= base_address_r;
        end
      endcase
    end
  end

  asa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_if        (in_if),
    .out_if       (out_if),
    .base_address (base_address_r),
    .capacity     (capacity_r),
    .mem_req      (mem_req),
    .mem_rd       (mem_rd)
  );

  asa_frame_ram u_frame_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

endmodule

// ===== hdl/asa_frame_ram.sv =====
module asa_frame_ram (
  input  logic              clk,
  input  asa_pkg::mem_req_t req,
  output asa_pkg::frame_t   rd_data
);

  asa_pkg::frame_t mem_r [asa_pkg::MAX_FRAMES];
  asa_pkg::frame_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/asa_ctrl.sv =====
`include "aligned_stack_allocator_top_macros.svh"

module asa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  asa_req_if.sink           in_if,
  asa_rsp_if.source         out_if,
  input  logic [31:0]       base_address,
  input  logic [31:0]       capacity,
  output asa_pkg::mem_req_t mem_req,
  input  asa_pkg::frame_t   mem_rd
);

  asa_pkg::state_t state_r, state_nxt;

  logic [31:0]                  used_r, used_nxt;
  logic [asa_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [31:0]                  out_address_r;
  asa_pkg::status_t             out_status_r;

  logic                         op_r;
  logic [31:0]                  size_r;
  logic                         check_top_r;
  logic [31:0]                  free_address_r;
  logic [31:0]                  first_payload_r;
  logic [asa_pkg::PAD_W-1:0]    pad_r;
  logic [31:0]                  free_space_r;

  logic                         acc;
  logic                         calc_fire;
  logic [31:0]                  first_payload;
  logic [asa_pkg::PAD_W-1:0]    pad;
  logic [32:0]                  total;
  logic                         full;
  logic                         push;
  logic                         pop;
  asa_pkg::status_t             status;
  logic [31:0]                  payload;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      asa_pkg::S_IDLE: begin
        if (acc) begin
          state_nxt = asa_pkg::S_CALC;
        end
      end
      asa_pkg::S_CALC: begin
        if (calc_fire) begin
          state_nxt = asa_pkg::S_IDLE;
        end
      end
      default: state_nxt = asa_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_if.ready = 1'b0;
    calc_fire   = 1'b0;
    case (state_r)
      asa_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
      end
      asa_pkg::S_CALC: begin
        calc_fire = !out_valid_r || out_if.ready;
      end
      default: begin
        in_if.ready = 1'b0;
      end
    endcase
  end

  assign acc = in_if.valid && in_if.ready;

  // request-side precompute
  assign first_payload = base_address + used_r + 32'(asa_pkg::HEADER_SIZE);
  assign pad = (asa_pkg::PAD_W'(0) - first_payload[asa_pkg::PAD_W-1:0])
             & asa_pkg::align_mask(in_if.align_log2);

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r            <= in_if.op;
      size_r          <= in_if.size;
      check_top_r     <= in_if.check_top;
      free_address_r  <= in_if.free_address;
      first_payload_r <= first_payload;
      pad_r           <= pad;
      free_space_r    <= (capacity >= used_r) ? (capacity - used_r) : 32'd0;
    end
  end

  // top-of-stack read at request time, frame write on a push at update
  always_comb begin
    mem_req.re    = acc;
    mem_req.raddr = asa_pkg::FRAME_IDX_W'(count_r - asa_pkg::COUNT_W'(1));
    mem_req.we    = calc_fire && push;
    mem_req.waddr = count_r[asa_pkg::FRAME_IDX_W-1:0];
    mem_req.wdata = '{frame_start: used_r, payload: payload};
  end

  assign total   = 33'(size_r) + 33'(pad_r) + 33'(asa_pkg::HEADER_SIZE);
  assign full    = count_r >= asa_pkg::COUNT_W'(asa_pkg::MAX_FRAMES);
  assign payload = first_payload_r + 32'(pad_r);

  always_comb begin
    push   = 1'b0;
    pop    = 1'b0;
    status = asa_pkg::STAT_OK;
    if (op_r == asa_pkg::OP_ALLOC) begin
      if (full) begin
        status = asa_pkg::STAT_FULL;
      end else if (total > {1'b0, free_space_r}) begin
        status = asa_pkg::STAT_NO_SPACE;
      end else begin
        push = 1'b1;
      end
    end else begin
      if (count_r == '0) begin
        status = asa_pkg::STAT_EMPTY;
      end else if (check_top_r && (free_address_r != mem_rd.payload)) begin
        status = asa_pkg::STAT_NOT_TOP;
      end else begin
        pop = 1'b1;
      end
    end
  end

  always_comb begin
    used_nxt      = used_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (calc_fire) begin
      out_valid_nxt = 1'b1;
      if (push) begin
        used_nxt  = used_r + total[31:0];
        count_nxt = count_r + asa_pkg::COUNT_W'(1);
      end else if (pop) begin
        used_nxt  = mem_rd.frame_start;
        count_nxt = count_r - asa_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= asa_pkg::S_IDLE;
      used_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_fire) begin
      out_address_r <= push ? payload : 32'd0;
      out_status_r  <= status;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.address = out_address_r;
  assign out_if.status  = out_status_r;

  `ASA_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= asa_pkg::COUNT_W'(asa_pkg::MAX_FRAMES))
  `ASA_ASSERT_NEXT(a_accept_calc, clk, rst_n, acc, state_r == asa_pkg::S_CALC)
  `ASA_ASSERT_NEXT(a_push_count, clk, rst_n, calc_fire && push, count_r == $past(count_r) + asa_pkg::COUNT_W'(1))
  `ASA_ASSERT_NEXT(a_reject_hold, clk, rst_n, calc_fire && !push && !pop, $stable(count_r) && $stable(used_r))

endmodule
